@@ rtl/lmte_pkg.sv @@
package lmte_pkg;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_HEAD_RED       = 3'd0;
   localparam logic [2:0] REG_HEAD_GREEN     = 3'd1;
   localparam logic [2:0] REG_HEAD_BLUE      = 3'd2;
   localparam logic [2:0] REG_METEOR_LENGTH  = 3'd3;
   localparam logic [2:0] REG_TRAIL_DECAY    = 3'd4;
   localparam logic [2:0] REG_RANDOM_DECAY   = 3'd5;

   // Item kinds.
   localparam logic KIND_RESTART = 1'b0;
   localparam logic KIND_FRAME   = 1'b1;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;
   localparam int CHAN_W      = 8;
   localparam int COLOR_W     = 3 * CHAN_W;
   localparam int MASK_W      = 10;
   localparam int PIX_INDEX_W = 4;
   localparam int POSITION_W  = 5;

   // Channels at or below this level go straight to black.
   localparam logic [CHAN_W-1:0] FADE_FLOOR = 8'd10;

   localparam logic [CHAN_W-1:0] RESET_HEAD_CHAN = 8'd255;
   localparam logic [CHAN_W-1:0] RESET_LENGTH    = 8'd10;
   localparam logic [CHAN_W-1:0] RESET_DECAY     = 8'd64;

   typedef struct packed {
      logic start;   // item accepted this cycle
      logic step;    // current pixel is processed and emitted this cycle
   } cmd_type;

   typedef struct packed {
      logic out_stall;   // result register full and not being taken
   } status_type;

endpackage

@@ rtl/led_meteor_trail_engine_core.sv @@
// Meteor-rain effect engine for a short RGB strip. Each accepted item is either a restart,
// which blacks out the strip and returns the head to position 0, or a frame, which fades
// each pixel whose mask bit is set (every pixel while random decay is off), paints the
// head colour over the meteor_length pixels ending at the head and moves the head on,
// wrapping after twice the pixel count. Either way the whole strip is returned as
// PIXEL_COUNT results, pixel 0 first, with last_pixel set on the final one. Pixel colours
// live in a single-port-write RAM that is walked one pixel per cycle unless back-pressure
// on the result side stalls it. The next item is taken once the last is fully walked.
// The strip reads as black after reset without any clearing pass. Configuration registers
// are always ready and should only be written while no item is in progress.
module led_meteor_trail_engine_core #(
   parameter int PIXEL_COUNT = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic [lmte_pkg::MASK_W-1:0]           req_fade_mask,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [lmte_pkg::PIX_INDEX_W-1:0]      rsp_pixel_index,
   output logic [lmte_pkg::CHAN_W-1:0]           rsp_out_red,
   output logic [lmte_pkg::CHAN_W-1:0]           rsp_out_green,
   output logic [lmte_pkg::CHAN_W-1:0]           rsp_out_blue,
   output logic [lmte_pkg::POSITION_W-1:0]       rsp_frame_position,
   output logic                                  rsp_last_pixel,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lmte_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lmte_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import lmte_pkg::*;

   localparam int IW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

   cmd_type            cmd;
   status_type         status;
   logic [IW-1:0]      pix_idx, rd_addr;
   logic               wr_en;
   logic [COLOR_W-1:0] wr_data, rd_data;

   lmte_ctrl #(.PIXEL_COUNT(PIXEL_COUNT)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd),
      .pix_idx   (pix_idx),
      .rd_addr   (rd_addr)
   );

   lmte_ram #(.WIDTH(COLOR_W), .DEPTH(PIXEL_COUNT)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pix_idx),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lmte_dp #(.PIXEL_COUNT(PIXEL_COUNT)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .pix_idx            (pix_idx),
      .rd_data            (rd_data),
      .wr_en              (wr_en),
      .wr_data            (wr_data),
      .req_kind           (req_kind),
      .req_fade_mask      (req_fade_mask),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pixel_index    (rsp_pixel_index),
      .rsp_out_red        (rsp_out_red),
      .rsp_out_green      (rsp_out_green),
      .rsp_out_blue       (rsp_out_blue),
      .rsp_frame_position (rsp_frame_position),
      .rsp_last_pixel     (rsp_last_pixel)
   );

endmodule

@@ rtl/lmte_ram.sv @@
module lmte_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 10
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lmte_ctrl.sv @@
module lmte_ctrl #(
   parameter int PIXEL_COUNT = 10
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              req_valid,
   output logic                                              req_ready,
   input  lmte_pkg::status_type                              status,
   output lmte_pkg::cmd_type                                 cmd,
   output logic [(PIXEL_COUNT > 1 ? $clog2(PIXEL_COUNT) : 1)-1:0] pix_idx,
   output logic [(PIXEL_COUNT > 1 ? $clog2(PIXEL_COUNT) : 1)-1:0] rd_addr
);
   import lmte_pkg::*;

   localparam int IW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(PIXEL_COUNT - 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic          state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          start, step, last;

   assign req_ready = (state_ff == ST_IDLE);
   assign start     = req_valid && req_ready;
   assign step      = (state_ff == ST_RUN) && !status.out_stall;
   assign last      = (idx_ff == LAST_IDX);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               idx_in   = '0;
            end
         end
         ST_RUN: begin
            if (step) begin
               if (last) begin
                  state_in = ST_IDLE;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            idx_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // The read runs one pixel ahead, so the stored colour is ready when the pixel is due.
   assign rd_addr = idx_in;
   assign pix_idx = idx_ff;

   always_comb begin
      cmd       = '0;
      cmd.start = start;
      cmd.step  = step;
   end

endmodule

@@ rtl/lmte_dp.sv @@
module lmte_dp #(
   parameter int PIXEL_COUNT = 10
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  lmte_pkg::cmd_type                                 cmd,
   output lmte_pkg::status_type                              status,
   input  logic [(PIXEL_COUNT > 1 ? $clog2(PIXEL_COUNT) : 1)-1:0] pix_idx,
   input  logic [lmte_pkg::COLOR_W-1:0]                      rd_data,
   output logic                                              wr_en,
   output logic [lmte_pkg::COLOR_W-1:0]                      wr_data,
   input  logic                                              req_kind,
   input  logic [lmte_pkg::MASK_W-1:0]                       req_fade_mask,
   input  logic                                              csr_valid,
   output logic                                              csr_ready,
   input  logic [lmte_pkg::CSR_INDEX_W-1:0]                  csr_index,
   input  logic [lmte_pkg::CSR_DATA_W-1:0]                   csr_wdata,
   output logic                                              rsp_valid,
   input  logic                                              rsp_ready,
   output logic [lmte_pkg::PIX_INDEX_W-1:0]                  rsp_pixel_index,
   output logic [lmte_pkg::CHAN_W-1:0]                       rsp_out_red,
   output logic [lmte_pkg::CHAN_W-1:0]                       rsp_out_green,
   output logic [lmte_pkg::CHAN_W-1:0]                       rsp_out_blue,
   output logic [lmte_pkg::POSITION_W-1:0]                   rsp_frame_position,
   output logic                                              rsp_last_pixel
);
   import lmte_pkg::*;

   localparam int IW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam int HW = $clog2(2 * PIXEL_COUNT);
   localparam logic [IW-1:0] LAST_IDX = IW'(PIXEL_COUNT - 1);
   localparam logic [HW-1:0] WRAP_POS = HW'(2 * PIXEL_COUNT - 1);
   localparam int DW = 9;

   function automatic logic [CHAN_W-1:0] fade_chan(input logic [CHAN_W-1:0] v,
                                                   input logic [CHAN_W-1:0] decay);
      logic [2*CHAN_W-1:0] prod;
      prod = v * decay;
      if (v <= FADE_FLOOR) begin
         return '0;
      end
      return v - prod[2*CHAN_W-1:CHAN_W];
   endfunction

   // Configuration registers.
   logic [CHAN_W-1:0] head_red_ff, head_green_ff, head_blue_ff;
   logic [CHAN_W-1:0] length_ff, decay_ff;
   logic              random_on_ff;

   // Per-item state.
   logic [HW-1:0]     head_ff, head_in;
   logic [HW-1:0]     pos_ff;
   logic              kind_ff;
   logic [MASK_W-1:0] mask_ff;
   logic [PIXEL_COUNT-1:0] valid_ff;

   // Result register.
   logic                   rsp_valid_ff;
   logic [PIX_INDEX_W-1:0] rsp_index_ff;
   logic [COLOR_W-1:0]     rsp_color_ff;
   logic [POSITION_W-1:0]  rsp_pos_ff;
   logic                   rsp_last_ff;

   logic [COLOR_W-1:0] cur_color, faded, new_color;
   logic               keep, fade_on, paint;
   logic [DW-1:0]      head_gap;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_red_ff   <= RESET_HEAD_CHAN;
         head_green_ff <= RESET_HEAD_CHAN;
         head_blue_ff  <= RESET_HEAD_CHAN;
         length_ff     <= RESET_LENGTH;
         decay_ff      <= RESET_DECAY;
         random_on_ff  <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            REG_HEAD_RED:      head_red_ff   <= csr_wdata;
            REG_HEAD_GREEN:    head_green_ff <= csr_wdata;
            REG_HEAD_BLUE:     head_blue_ff  <= csr_wdata;
            REG_METEOR_LENGTH: length_ff     <= csr_wdata;
            REG_TRAIL_DECAY:   decay_ff      <= csr_wdata;
            REG_RANDOM_DECAY:  random_on_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      head_in = head_ff;
      if (cmd.start) begin
         if (req_kind == KIND_RESTART || head_ff == WRAP_POS) begin
            head_in = '0;
         end else begin
            head_in = head_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else begin
         head_ff <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         kind_ff <= req_kind;
         mask_ff <= req_fade_mask;
         pos_ff  <= (req_kind == KIND_RESTART) ? '0 : head_ff;
      end
   end

   // A pixel never written since reset reads as black.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.step) begin
         valid_ff[pix_idx] <= 1'b1;
      end
   end

   always_comb begin
      cur_color = valid_ff[pix_idx] ? rd_data : '0;
      keep      = (32'(pix_idx) < MASK_W) && mask_ff[PIX_INDEX_W'(pix_idx)];
      fade_on   = !random_on_ff || keep;
      faded     = {fade_chan(cur_color[3*CHAN_W-1:2*CHAN_W], decay_ff),
                   fade_chan(cur_color[2*CHAN_W-1:CHAN_W], decay_ff),
                   fade_chan(cur_color[CHAN_W-1:0], decay_ff)};
      head_gap  = DW'(pos_ff) - DW'(pix_idx);
      paint     = (DW'(pix_idx) <= DW'(pos_ff)) && (head_gap < DW'(length_ff));
      if (kind_ff == KIND_RESTART) begin
         new_color = '0;
      end else if (paint) begin
         new_color = {head_red_ff, head_green_ff, head_blue_ff};
      end else if (fade_on) begin
         new_color = faded;
      end else begin
         new_color = cur_color;
      end
   end

   assign wr_en   = cmd.step;
   assign wr_data = new_color;

   assign status.out_stall = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         rsp_index_ff <= PIX_INDEX_W'(pix_idx);
         rsp_color_ff <= new_color;
         rsp_pos_ff   <= POSITION_W'(pos_ff);
         rsp_last_ff  <= (pix_idx == LAST_IDX);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_index    = rsp_index_ff;
   assign rsp_out_red        = rsp_color_ff[3*CHAN_W-1:2*CHAN_W];
   assign rsp_out_green      = rsp_color_ff[2*CHAN_W-1:CHAN_W];
   assign rsp_out_blue       = rsp_color_ff[CHAN_W-1:0];
   assign rsp_frame_position = rsp_pos_ff;
   assign rsp_last_pixel     = rsp_last_ff;

endmodule

@@ dv/tb_led_meteor_trail_engine_core.sv @@
module tb_led_meteor_trail_engine_core;
   timeunit 1ns;
   timeprecision 1ps;

   import lmte_pkg::*;

   localparam int PIXELS      = 10;
   localparam int QUIET_LIMIT = 2000;

   // Indexes that decode to no register; writes to them must leave the settings alone.
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [PIX_INDEX_W-1:0] pixel_index;
      logic [CHAN_W-1:0]      red;
      logic [CHAN_W-1:0]      green;
      logic [CHAN_W-1:0]      blue;
      logic [POSITION_W-1:0]  position;
      logic                   last;
   } pixel_result_type;

   class meteor_strip_scoreboard;
      pixel_result_type  expected_pixels[$];
      logic [CHAN_W-1:0] strip_red[PIXELS];
      logic [CHAN_W-1:0] strip_green[PIXELS];
      logic [CHAN_W-1:0] strip_blue[PIXELS];
      int                head;
      logic [CHAN_W-1:0] head_red, head_green, head_blue;
      logic [CHAN_W-1:0] meteor_len, decay;
      logic              random_decay;
      int                mismatches, items_seen, restarts_seen, results_seen, settings_seen;

      function new();
         head_red     = RESET_HEAD_CHAN;
         head_green   = RESET_HEAD_CHAN;
         head_blue    = RESET_HEAD_CHAN;
         meteor_len   = RESET_LENGTH;
         decay        = RESET_DECAY;
         random_decay = 1'b1;
         head         = 0;
         for (int p = 0; p < PIXELS; p++) begin
            strip_red[p]   = '0;
            strip_green[p] = '0;
            strip_blue[p]  = '0;
         end
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_HEAD_RED:      head_red     = data;
            REG_HEAD_GREEN:    head_green   = data;
            REG_HEAD_BLUE:     head_blue    = data;
            REG_METEOR_LENGTH: meteor_len   = data;
            REG_TRAIL_DECAY:   decay        = data;
            REG_RANDOM_DECAY:  random_decay = data[0];
            default: ;
         endcase
      endfunction

      function logic [CHAN_W-1:0] faded(logic [CHAN_W-1:0] v);
         logic [2*CHAN_W-1:0] product;
         product = v * decay;
         if (v <= FADE_FLOOR) return '0;
         return v - product[2*CHAN_W-1:CHAN_W];
      endfunction

      function void note_item(logic kind, logic [MASK_W-1:0] mask);
         int               pos;
         logic             may_fade;
         pixel_result_type r;
         items_seen++;
         if (kind == KIND_RESTART) begin
            restarts_seen++;
            for (int p = 0; p < PIXELS; p++) begin
               strip_red[p]   = '0;
               strip_green[p] = '0;
               strip_blue[p]  = '0;
            end
            head = 0;
            pos  = 0;
         end else begin
            pos = head;
            for (int p = 0; p < PIXELS; p++) begin
               may_fade = (p < MASK_W) ? mask[p] : 1'b0;
               if (!random_decay || may_fade) begin
                  strip_red[p]   = faded(strip_red[p]);
                  strip_green[p] = faded(strip_green[p]);
                  strip_blue[p]  = faded(strip_blue[p]);
               end
            end
            for (int p = 0; p < PIXELS; p++) begin
               if (p <= pos && pos - p < int'(meteor_len)) begin
                  strip_red[p]   = head_red;
                  strip_green[p] = head_green;
                  strip_blue[p]  = head_blue;
               end
            end
            head = (pos + 1 >= 2 * PIXELS) ? 0 : pos + 1;
         end
         for (int p = 0; p < PIXELS; p++) begin
            r.pixel_index = PIX_INDEX_W'(p);
            r.red         = strip_red[p];
            r.green       = strip_green[p];
            r.blue        = strip_blue[p];
            r.position    = POSITION_W'(pos);
            r.last        = (p == PIXELS - 1);
            expected_pixels.push_back(r);
         end
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(pixel_result_type got);
         pixel_result_type want;
         results_seen++;
         if (expected_pixels.size() == 0) begin
            $error("pixel result %0d arrived with nothing outstanding", got.pixel_index);
            mismatches++;
            return;
         end
         want = expected_pixels.pop_front();
         compare_field("pixel_index", 8'(want.pixel_index), 8'(got.pixel_index));
         compare_field("out_red", want.red, got.red);
         compare_field("out_green", want.green, got.green);
         compare_field("out_blue", want.blue, got.blue);
         compare_field("frame_position", 8'(want.position), 8'(got.position));
         compare_field("last_pixel", 8'(want.last), 8'(got.last));
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_kind = KIND_RESTART;
   logic [MASK_W-1:0]      req_fade_mask = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [PIX_INDEX_W-1:0] rsp_pixel_index;
   logic [CHAN_W-1:0]      rsp_out_red;
   logic [CHAN_W-1:0]      rsp_out_green;
   logic [CHAN_W-1:0]      rsp_out_blue;
   logic [POSITION_W-1:0]  rsp_frame_position;
   logic                   rsp_last_pixel;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   meteor_strip_scoreboard frames = new();
   int send_idle_pct = 19;
   int rsp_idle_pct  = 69;
   int quiet_cycles  = 0;

   led_meteor_trail_engine_core #(.PIXEL_COUNT(PIXELS)) u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         frames.check_result('{rsp_pixel_index, rsp_out_red, rsp_out_green, rsp_out_blue,
                               rsp_frame_position, rsp_last_pixel});
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timed out with %0d pixel results outstanding.", frames.pending());
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic kind, input logic [MASK_W-1:0] mask);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_fade_mask <= mask;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      frames.note_item(kind, mask);
   endtask

   task automatic stop_items();
      req_valid <= 1'b0;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      frames.set_register(idx, data);
   endtask

   task automatic configure(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue, input logic [7:0] len,
                            input logic [7:0] fade, input logic [7:0] random_word);
      write_reg(REG_HEAD_RED, red);
      write_reg(REG_HEAD_GREEN, green);
      write_reg(REG_HEAD_BLUE, blue);
      write_reg(REG_METEOR_LENGTH, len);
      write_reg(REG_TRAIL_DECAY, fade);
      write_reg(REG_RANDOM_DECAY, random_word);
      csr_valid <= 1'b0;
      frames.settings_seen++;
   endtask

   // Waits until the strip is fully returned, then lets the block settle before
   // the settings change.
   task automatic drain_results();
      while (frames.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_level();
      case ($urandom_range(5))
         0: return 8'd0;
         1: return 8'd255;
         2: return FADE_FLOOR;
         3: return FADE_FLOOR + 8'd1;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [7:0] pick_length();
      case ($urandom_range(5))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'($urandom_range(PIXELS - 1, PIXELS + 1));
         3: return 8'd255;
         default: return 8'($urandom_range(2, 2 * PIXELS));
      endcase
   endfunction

   function automatic logic [MASK_W-1:0] pick_mask();
      case ($urandom_range(7))
         0: return '1;
         1: return '0;
         default: return MASK_W'($urandom);
      endcase
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Settings as left by reset: full white head, ten pixels, moderate fade.
      repeat (3) send_item(KIND_FRAME, 10'h3FF);
      send_item(KIND_FRAME, 10'h000);
      send_item(KIND_FRAME, 10'h2AA);
      send_item(KIND_FRAME, 10'h155);
      send_item(KIND_RESTART, 10'h3FF);
      stop_items();
      drain_results();

      // Heaviest fade with the mask switched off, so channels near the floor go black.
      write_reg(REG_SPARE_LO, 8'hFF);
      write_reg(REG_SPARE_HI, 8'h5A);
      configure(8'd255, 8'd11, 8'd10, 8'd3, 8'd255, 8'hFE);
      send_item(KIND_FRAME, 10'h000);
      send_item(KIND_FRAME, 10'h3FF);
      send_item(KIND_FRAME, 10'h000);
      send_item(KIND_FRAME, 10'h000);
      stop_items();
      drain_results();

      // No meteor at all: the strip only fades.
      configure(8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 8'h03);
      send_item(KIND_FRAME, 10'h3FF);
      send_item(KIND_FRAME, 10'h000);
      send_item(KIND_FRAME, 10'h3FF);
      send_item(KIND_FRAME, 10'h001);
      stop_items();
      drain_results();

      // Longest meteor and no fade at all.
      configure(8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'h80);
      repeat (3) send_item(KIND_FRAME, 10'h3FF);
      send_item(KIND_RESTART, 10'h000);
      send_item(KIND_FRAME, 10'h200);
      stop_items();
      drain_results();

      for (int seg = 0; seg < 10; seg++) begin
         if (seg == 3) begin
            send_idle_pct = 69;
            rsp_idle_pct  = 19;
         end else if (seg == 7) begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         if ($urandom_range(3) == 0) write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                                               8'($urandom));
         configure(pick_level(), pick_level(), pick_level(), pick_length(), pick_level(),
                   8'($urandom));
         // Restarts are kept rare so that the head wraps round now and then.
         repeat (31) send_item(($urandom_range(24) == 0) ? KIND_RESTART : KIND_FRAME,
                               pick_mask());
         stop_items();
         drain_results();
      end

      repeat (2 * PIXELS) @(posedge clock);
      $display("Ran %0d items, %0d of them restarts, under %0d sets of register values.",
               frames.items_seen, frames.restarts_seen, frames.settings_seen);
      $display("Checked %0d pixel results; %0d field mismatches.",
               frames.results_seen, frames.mismatches);
      if (frames.mismatches == 0 && frames.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ led_meteor_trail_engine_core.f @@
rtl/lmte_pkg.sv
rtl/lmte_ram.sv
rtl/lmte_ctrl.sv
rtl/lmte_dp.sv
rtl/led_meteor_trail_engine_core.sv
dv/tb_led_meteor_trail_engine_core.sv
